[rtl/core/assert_macros.svh]
// Assertion macros shared by the display refresh RTL.
// Defining NO_ASSERTIONS turns every use into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[rtl/core/clnr_pkg.sv]
// Types, constants and helper functions of the character display refresh engine.
// No dependencies; used by clnr_text_store and char_lcd_nibble_refresh.
`timescale 1ns / 1ps

package clnr_pkg;

  // Default store geometry
  localparam int DEF_MAX_COLUMNS = 40;
  localparam int DEF_MAX_ROWS    = 4;

  // Expander byte bit positions
  localparam int BIT_RS = 0;
  localparam int BIT_EN = 2;
  localparam int BIT_BL = 3;

  localparam logic [7:0] CMD_DDRAM = 8'h80;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Register reset values
  localparam logic [5:0]  COLS_RESET  = 6'd16;
  localparam logic [2:0]  ROWS_RESET  = 3'd2;
  localparam logic [15:0] ORDER_RESET = 16'h7710;

  // Nibble phases: three bytes per nibble, high nibble first
  localparam logic [2:0] PH_HI_EN  = 3'd1;
  localparam logic [2:0] PH_LO_FIRST = 3'd3;
  localparam logic [2:0] PH_LO_EN  = 3'd4;
  localparam logic [2:0] PH_LAST   = 3'd5;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_COLUMN_COUNT = 2'd0,
    CFG_ROW_COUNT    = 2'd1,
    CFG_BACKLIGHT    = 2'd2,
    CFG_ROW_ORDER    = 2'd3
  } cfg_idx_t;

  // Text store write request
  typedef struct packed {
    logic       en;
    logic [1:0] row;
    logic [5:0] col;
    logic [7:0] data;
  } store_wr_t;

  // Text store read request
  typedef struct packed {
    logic       en;
    logic [2:0] row;
    logic [5:0] col;
  } store_rd_t;

  // DDRAM start address of each display line
  function automatic logic [7:0] line_base(input logic [1:0] drow);
    logic [7:0] base;
    case (drow)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

endpackage

[rtl/core/char_lcd_nibble_refresh.sv]
// Channel  | Ports                    | Contents
// in       | in_tvalid/tready/tdata/tuser | tuser: mode; tdata: row, col, char
// out      | out_tvalid/tready/tdata/tlast/tuser | tdata: expander byte
// cfg      | cfg_we/cfg_index/cfg_data | register writes, no read-back
//
// One item per cycle while the output is not stalled; an advance item's byte
// reaches the output through the store read register, then the output register.
// Synchronous active-low reset clears the sequencer, registers and store valid bits.
// A stalled output holds its byte while one more item waits in the read stage.
//
// Top level of the character display refresh engine. Depends on clnr_pkg,
// clnr_text_store and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module char_lcd_nibble_refresh
  import clnr_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] text_row, [7:2] text_col, [15:8] char_code
  input  logic        in_tuser,   // [0] mode
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // end_of_row
  output logic        out_tuser,  // [0] end_of_frame
  // Configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [5:0]  col_count_r;
  logic [2:0]  row_count_r;
  logic        backlight_r;
  logic [15:0] row_order_r;

  // Sequencer state
  logic [1:0] drow_r, drow_nxt;
  logic [5:0] slot_r, slot_nxt;
  logic [2:0] phase_r, phase_nxt;

  // Read stage
  logic       s1_v_r;
  logic       s1_cmd_r;
  logic [1:0] s1_drow_r;
  logic [2:0] s1_phase_r;
  logic       s1_bl_r;
  logic       s1_eor_r;
  logic       s1_eof_r;

  // Output register
  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic       out_eor_r;
  logic       out_eof_r;

  logic       in_acc, adv_acc, out_ld;
  logic [6:0] cols_eff;
  logic [2:0] rows_eff;
  logic       is_cmd, last_slot, eor, eof;
  logic [2:0] trow;
  logic [5:0] col;
  store_wr_t  st_wr;
  store_rd_t  st_rd;
  logic [7:0] rd_char;
  logic [7:0] val;
  logic [3:0] nib;
  logic       en_bit;
  logic [7:0] byte_nxt;

  // Handshake
  assign out_ld    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || out_ld;
  assign in_acc    = in_tvalid && in_tready;
  assign adv_acc   = in_acc && in_tuser;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= COLS_RESET;
      row_count_r <= ROWS_RESET;
      backlight_r <= 1'b0;
      row_order_r <= ORDER_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COLUMN_COUNT: col_count_r <= cfg_data[5:0];
        CFG_ROW_COUNT:    row_count_r <= cfg_data[2:0];
        CFG_BACKLIGHT:    backlight_r <= cfg_data[0];
        CFG_ROW_ORDER:    row_order_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Effective geometry: clamp columns to the store, rows to 1..MAX_ROWS
  always_comb begin
    cols_eff = ({1'b0, col_count_r} > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS)
                                                       : {1'b0, col_count_r};
    if (row_count_r == 3'd0) begin
      rows_eff = 3'd1;
    end else if (row_count_r > 3'(MAX_ROWS)) begin
      rows_eff = 3'(MAX_ROWS);
    end else begin
      rows_eff = row_count_r;
    end
  end

  // Slot decode for the current advance
  always_comb begin
    is_cmd    = (slot_r == 6'd0);
    col       = slot_r - 6'd1;
    trow      = row_order_r[{drow_r, 2'b00} +: 3];
    last_slot = ({1'b0, slot_r} >= cols_eff);
    eor       = (phase_r == PH_LAST) && last_slot;
    eof       = eor && (({1'b0, drow_r} + 3'd1) >= rows_eff);
  end

  // Store requests
  always_comb begin
    st_wr.en   = in_acc && !in_tuser && ({1'b0, in_tdata[7:2]} < cols_eff);
    st_wr.row  = in_tdata[1:0];
    st_wr.col  = in_tdata[7:2];
    st_wr.data = in_tdata[15:8];
    st_rd.en   = adv_acc && !is_cmd;
    st_rd.row  = trow;
    st_rd.col  = col;
  end

  clnr_text_store #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (st_wr),
    .rd      (st_rd),
    .rd_char (rd_char)
  );

  // Advance phase, slot and display row
  always_comb begin
    drow_nxt  = drow_r;
    slot_nxt  = slot_r;
    phase_nxt = phase_r;
    if (phase_r < PH_LAST) begin
      phase_nxt = phase_r + 3'd1;
    end else begin
      phase_nxt = 3'd0;
      if (!last_slot) begin
        slot_nxt = slot_r + 6'd1;
      end else begin
        slot_nxt = 6'd0;
        drow_nxt = eof ? 2'd0 : drow_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drow_r  <= 2'd0;
      slot_r  <= 6'd0;
      phase_r <= 3'd0;
    end else if (adv_acc) begin
      drow_r  <= drow_nxt;
      slot_r  <= slot_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Read stage: capture the slot context beside the store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv_acc) begin
      s1_v_r <= 1'b1;
    end else if (out_ld) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_acc) begin
      s1_cmd_r   <= is_cmd;
      s1_drow_r  <= drow_r;
      s1_phase_r <= phase_r;
      s1_bl_r    <= backlight_r;
      s1_eor_r   <= eor;
      s1_eof_r   <= eof;
    end
  end

  // Build the expander byte
  always_comb begin
    val    = s1_cmd_r ? (CMD_DDRAM | line_base(s1_drow_r)) : rd_char;
    nib    = (s1_phase_r < PH_LO_FIRST) ? val[7:4] : val[3:0];
    en_bit = s1_phase_r inside {PH_HI_EN, PH_LO_EN};
    byte_nxt         = {nib, 4'b0000};
    byte_nxt[BIT_BL] = s1_bl_r;
    byte_nxt[BIT_EN] = en_bit;
    byte_nxt[BIT_RS] = !s1_cmd_r;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_byte_r <= byte_nxt;
      out_eor_r  <= s1_eor_r;
      out_eof_r  <= s1_eof_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_eor_r;
  assign out_tuser  = out_eof_r;

  // Checks
  `ASSERT_CLK(a_eof_has_eor, clk, rst_n, (out_tvalid && out_tuser) |-> out_tlast, "end of frame without end of row")
  `ASSERT_NEVER(a_phase_range, clk, rst_n, phase_r > PH_LAST, "nibble phase out of range")
  `ASSERT_CLK(a_frame_wrap, clk, rst_n, (adv_acc && eof) |=> (slot_r == 6'd0 && drow_r == 2'd0 && phase_r == 3'd0), "sequencer did not wrap at end of frame")
  `ASSERT_CLK(a_ready_when_empty, clk, rst_n, !s1_v_r |-> in_tready, "input stalled with empty read stage")

endmodule

[rtl/core/clnr_text_store.sv]
// Text store: MAX_ROWS x MAX_COLUMNS character memory with per-entry valid bits.
// Unwritten or out-of-range entries read as a space. Depends on clnr_pkg.
`timescale 1ns / 1ps

module clnr_text_store
  import clnr_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  store_wr_t  wr,
  input  store_rd_t  rd,
  output logic [7:0] rd_char
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [7:0] mem [MAX_ROWS][MAX_COLUMNS];
  logic       vld_r [MAX_ROWS][MAX_COLUMNS];
  logic [7:0] rd_mem_r;
  logic       rd_ok_r;

  logic             wr_hit;
  logic             rd_hit;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;
  logic [ROW_W-1:0] rd_row;
  logic [COL_W-1:0] rd_col;

  // Decode addresses and range checks
  always_comb begin
    wr_row = wr.row[ROW_W-1:0];
    wr_col = wr.col[COL_W-1:0];
    rd_row = rd.row[ROW_W-1:0];
    rd_col = rd.col[COL_W-1:0];
    wr_hit = wr.en && ({1'b0, wr.row} < 3'(MAX_ROWS)) &&
             ({1'b0, wr.col} < 7'(MAX_COLUMNS));
    rd_hit = ({1'b0, rd.row} < 4'(MAX_ROWS)) &&
             ({1'b0, rd.col} < 7'(MAX_COLUMNS));
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_row][wr_col] <= wr.data;
    end
  end

  // Valid bits: cleared by reset so the store reads as spaces
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        for (int c = 0; c < MAX_COLUMNS; c++) begin
          vld_r[r][c] <= 1'b0;
        end
      end
    end else if (wr_hit) begin
      vld_r[wr_row][wr_col] <= 1'b1;
    end
  end

  // Registered read port; hold data until the next read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (rd_hit) begin
        rd_mem_r <= mem[rd_row][rd_col];
        rd_ok_r  <= vld_r[rd_row][rd_col];
      end else begin
        rd_mem_r <= CHAR_SPACE;
        rd_ok_r  <= 1'b0;
      end
    end
  end

  assign rd_char = rd_ok_r ? rd_mem_r : CHAR_SPACE;

endmodule
